@@ rtl/sdss_pkg.sv @@
package sdss_pkg;

  // request store and sorted list sizing
  localparam int unsigned MAX_REQUESTS = 32;
  localparam int unsigned LIST_MAX     = MAX_REQUESTS + 3;
  localparam int unsigned IDX_W        = $clog2(LIST_MAX);
  localparam int unsigned LEN_W        = $clog2(LIST_MAX + 1);
  localparam int unsigned CMP_W        = LEN_W + 1;

  localparam int unsigned TRACK_W    = 16;
  localparam int unsigned TOTAL_W    = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_TRACKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PREV_TRACK  = CFG_IDX_W'(2);

  localparam logic [CFG_DATA_W-1:0] DISK_TRACKS_RST = CFG_DATA_W'(200);

  // item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [TRACK_W-1:0] track;
  } item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] visit_track;
    logic [TOTAL_W-1:0] seek_total;
    logic               last;
  } result_t;

  // value to insert into the sorted list
  typedef enum logic [1:0] {
    VAL_TRACK,
    VAL_LAST,
    VAL_ZERO,
    VAL_HEAD
  } val_sel_e;

  typedef struct packed {
    logic     ins_load;
    val_sel_e val_sel;
    logic     ins_begin;
    logic     ins_cmp;
    logic     ins_fin;
    logic     emit_init;
    logic     emit_rd;
    logic     emit_out;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic pos_one;
    logic greater;
    logic more;
  } status_t;

  // last track of the disk, saturated to the track width
  function automatic logic [TRACK_W-1:0] last_track(input logic [CFG_DATA_W-1:0] dt);
    logic [CFG_DATA_W-1:0] m;
    m = dt - CFG_DATA_W'(1);
    if (dt == '0) begin
      return '0;
    end else if (dt > CFG_DATA_W'(65536)) begin
      return '1;
    end
    return m[TRACK_W-1:0];
  endfunction

endpackage

@@ rtl/sdss_ctrl.sv @@
module sdss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             cmd_i,
  input  sdss_pkg::status_t status_i,
  output sdss_pkg::ctrl_t   ctrl_o,
  output logic             busy_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_NEXT = 8'b0000_0010,
    ST_BEG  = 8'b0000_0100,
    ST_CMP  = 8'b0000_1000,
    ST_FIN  = 8'b0001_0000,
    ST_INIT = 8'b0010_0000,
    ST_ERD  = 8'b0100_0000,
    ST_EOUT = 8'b1000_0000
  } state_e;

  // which insertion is under way
  typedef enum logic [3:0] {
    PH_LOAD = 4'b0001,
    PH_LAST = 4'b0010,
    PH_ZERO = 4'b0100,
    PH_HEAD = 4'b1000
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   ins_done;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    ctrl_o   = '0;
    ins_done = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (cmd_i == sdss_pkg::CMD_START) begin
            phase_d = PH_LAST;
            state_d = ST_NEXT;
          end else if (!status_i.full) begin
            ctrl_o.ins_load = 1'b1;
            ctrl_o.val_sel  = sdss_pkg::VAL_TRACK;
            phase_d         = PH_LOAD;
            state_d         = ST_BEG;
          end
        end
      end
      ST_NEXT: begin
        ctrl_o.ins_load = 1'b1;
        case (phase_q)
          PH_LAST: ctrl_o.val_sel = sdss_pkg::VAL_LAST;
          PH_ZERO: ctrl_o.val_sel = sdss_pkg::VAL_ZERO;
          PH_HEAD: ctrl_o.val_sel = sdss_pkg::VAL_HEAD;
          default: ctrl_o.val_sel = sdss_pkg::VAL_TRACK;
        endcase
        state_d = ST_BEG;
      end
      ST_BEG: begin
        ctrl_o.ins_begin = 1'b1;
        if (status_i.pos_zero) begin
          ins_done = 1'b1;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl_o.ins_cmp = 1'b1;
        if (status_i.greater) begin
          if (status_i.pos_one) begin
            state_d = ST_FIN;
          end
        end else begin
          ins_done = 1'b1;
        end
      end
      ST_FIN: begin
        ctrl_o.ins_fin = 1'b1;
        ins_done       = 1'b1;
      end
      ST_INIT: begin
        ctrl_o.emit_init = 1'b1;
        state_d          = ST_ERD;
      end
      ST_ERD: begin
        ctrl_o.emit_rd = 1'b1;
        state_d        = ST_EOUT;
      end
      ST_EOUT: begin
        ctrl_o.emit_out = 1'b1;
        state_d         = status_i.more ? ST_ERD : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (ins_done) begin
      case (phase_q)
        PH_LOAD: state_d = ST_IDLE;
        PH_LAST: begin
          phase_d = PH_ZERO;
          state_d = ST_NEXT;
        end
        PH_ZERO: begin
          phase_d = PH_HEAD;
          state_d = ST_NEXT;
        end
        PH_HEAD: state_d = ST_INIT;
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_LOAD;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ rtl/sdss_datapath.sv @@
module sdss_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sdss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sdss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [sdss_pkg::TRACK_W-1:0]        track_i,
  input  sdss_pkg::ctrl_t                     ctrl_i,
  output sdss_pkg::status_t                   status_o,
  output logic                                result_valid_o,
  output sdss_pkg::result_t                   result_o
);

  localparam int unsigned IDX_W = sdss_pkg::IDX_W;
  localparam int unsigned LEN_W = sdss_pkg::LEN_W;
  localparam int unsigned CMP_W = sdss_pkg::CMP_W;
  localparam int unsigned TW    = sdss_pkg::TRACK_W;
  localparam int unsigned SW    = sdss_pkg::TOTAL_W;

  logic [sdss_pkg::CFG_DATA_W-1:0] disk_tracks_q;
  logic [TW-1:0]                   start_head_q;
  logic [TW-1:0]                   prev_track_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_tracks_q <= sdss_pkg::DISK_TRACKS_RST;
      start_head_q  <= '0;
      prev_track_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sdss_pkg::CFG_DISK_TRACKS: disk_tracks_q <= cfg_data_i;
        sdss_pkg::CFG_START_HEAD:  start_head_q  <= cfg_data_i[TW-1:0];
        sdss_pkg::CFG_PREV_TRACK:  prev_track_q  <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  logic [TW-1:0] lt;
  logic [TW-1:0] clamped;
  logic [TW-1:0] sel_val;

  assign lt      = sdss_pkg::last_track(disk_tracks_q);
  assign clamped = (track_i > lt) ? lt : track_i;

  always_comb begin
    case (ctrl_i.val_sel)
      sdss_pkg::VAL_TRACK: sel_val = clamped;
      sdss_pkg::VAL_LAST:  sel_val = lt;
      sdss_pkg::VAL_ZERO:  sel_val = '0;
      sdss_pkg::VAL_HEAD:  sel_val = start_head_q;
      default:             sel_val = clamped;
    endcase
  end

  // sorted list store, one write and one registered read a cycle
  logic [TW-1:0]    list_q [sdss_pkg::LIST_MAX];
  logic [TW-1:0]    rdata_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [TW-1:0]    wr_data;

  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] split_q, split_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [TW-1:0]    ins_val_q;
  logic             ge_q;
  logic             ins_done;
  logic             greater;
  logic             pos_zero;
  logic             pos_one;

  assign pos_zero = (pos_q == '0);
  assign pos_one  = (pos_q == IDX_W'(1));
  // the head goes in front of equal entries so that it marks the split
  assign greater  = ge_q ? (rdata_q >= ins_val_q) : (rdata_q > ins_val_q);

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_data  = ins_val_q;
    ins_done = 1'b0;
    pos_d    = pos_q;
    if (ctrl_i.ins_load) begin
      pos_d = IDX_W'(len_q);
    end
    if (ctrl_i.ins_begin) begin
      if (pos_zero) begin
        wr_en    = 1'b1;
        ins_done = 1'b1;
      end else begin
        rd_en   = 1'b1;
        rd_addr = pos_q - IDX_W'(1);
      end
    end
    if (ctrl_i.ins_cmp) begin
      wr_en = 1'b1;
      if (greater) begin
        wr_data = rdata_q;
        pos_d   = pos_q - IDX_W'(1);
        if (!pos_one) begin
          rd_en   = 1'b1;
          rd_addr = pos_q - IDX_W'(2);
        end
      end else begin
        ins_done = 1'b1;
      end
    end
    if (ctrl_i.ins_fin) begin
      wr_en    = 1'b1;
      ins_done = 1'b1;
    end
    if (ctrl_i.emit_rd) begin
      rd_en   = 1'b1;
      rd_addr = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      list_q[pos_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= list_q[rd_addr];
    end
  end

  // visit order bookkeeping
  logic             dir_up_q, dir_up_d;
  logic             second_q, second_d;
  logic             up_avail;
  logic             down_avail;
  logic             up_first;
  logic             more;
  logic [IDX_W-1:0] split_up;
  logic [IDX_W-1:0] split_dn;

  assign up_avail   = (CMP_W'(split_q) + CMP_W'(1)) < CMP_W'(len_q);
  assign down_avail = (split_q != '0);
  assign up_first   = (prev_track_q < start_head_q);
  assign split_up   = split_q + IDX_W'(1);
  assign split_dn   = split_q - IDX_W'(1);

  always_comb begin
    more     = 1'b0;
    idx_d    = idx_q;
    dir_up_d = dir_up_q;
    second_d = second_q;
    if (dir_up_q) begin
      if ((CMP_W'(idx_q) + CMP_W'(1)) < CMP_W'(len_q)) begin
        more  = 1'b1;
        idx_d = idx_q + IDX_W'(1);
      end else if (!second_q && down_avail) begin
        more     = 1'b1;
        idx_d    = split_dn;
        dir_up_d = 1'b0;
        second_d = 1'b1;
      end
    end else begin
      if (idx_q != '0) begin
        more  = 1'b1;
        idx_d = idx_q - IDX_W'(1);
      end else if (!second_q && up_avail) begin
        more     = 1'b1;
        idx_d    = split_up;
        dir_up_d = 1'b1;
        second_d = 1'b1;
      end
    end
    if (ctrl_i.emit_init) begin
      dir_up_d = up_first ? up_avail : !down_avail;
      second_d = up_first ? !up_avail : !down_avail;
      idx_d    = dir_up_d ? split_up : split_dn;
    end else if (!ctrl_i.emit_out) begin
      idx_d    = idx_q;
      dir_up_d = dir_up_q;
      second_d = second_q;
    end
  end

  always_comb begin
    len_d   = len_q;
    split_d = split_q;
    if (ins_done) begin
      len_d = len_q + LEN_W'(1);
      if (ge_q) begin
        split_d = pos_q;
      end
    end
    if (ctrl_i.emit_out && !more) begin
      len_d = '0;
    end
  end

  // seek distance
  logic [TW-1:0] head_q;
  logic [SW-1:0] sum_q;
  logic [TW-1:0] step_dist;
  logic [SW-1:0] sum_d;

  assign step_dist = (rdata_q > head_q) ? (rdata_q - head_q) : (head_q - rdata_q);
  assign sum_d     = sum_q + SW'(step_dist);

  sdss_pkg::result_t result_q;
  logic              valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      head_q   <= '0;
      sum_q    <= '0;
      valid_q  <= 1'b0;
      ge_q     <= 1'b0;
      dir_up_q <= 1'b0;
      second_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      valid_q  <= ctrl_i.emit_out;
      dir_up_q <= dir_up_d;
      second_q <= second_d;
      if (ctrl_i.ins_load) begin
        ge_q <= (ctrl_i.val_sel == sdss_pkg::VAL_HEAD);
      end
      if (ctrl_i.emit_init) begin
        head_q <= start_head_q;
        sum_q  <= '0;
      end else if (ctrl_i.emit_out) begin
        head_q <= rdata_q;
        sum_q  <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    split_q <= split_d;
    idx_q   <= idx_d;
    if (ctrl_i.ins_load) begin
      ins_val_q <= sel_val;
    end
    if (ctrl_i.emit_out) begin
      result_q.visit_track <= rdata_q;
      result_q.seek_total  <= sum_d;
      result_q.last        <= !more;
    end
  end

  assign status_o.full     = (len_q == LEN_W'(sdss_pkg::MAX_REQUESTS));
  assign status_o.pos_zero = pos_zero;
  assign status_o.pos_one  = pos_one;
  assign status_o.greater  = greater;
  assign status_o.more     = more;

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

@@ rtl/scan_disk_seek_scheduler.sv @@
// scan (elevator) seek scheduler. an item is taken when start_i is high and
// busy_o is low. a load item inserts its track, clamped to the last track, into
// a sorted list store; it is dropped, with busy_o left low, when the store
// already holds its full count of requests. a load keeps busy_o high while
// insertion shifts each stored track above the new one up by one entry, one
// entry a cycle through the single write port of the store. a start item
// inserts the last track, track 0 and the head the same way, then reads the
// list out in sweep order, each visit taking a registered store read and then
// a step that forms the running seek total. with n stored requests a run gives
// n + 2 visits. each visit is shown on result_o for exactly one cycle with
// result_valid_o high, never in consecutive cycles; the receiver cannot stall
// and must take it then. the final visit has last set and carries the total.
// configuration writes are taken at any time but belong in idle periods; a
// write to an index past the register list is ignored.
module scan_disk_seek_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // item channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  sdss_pkg::item_t                 item_i,

  // result channel, one transfer per strobe
  output logic                            result_valid_o,
  output sdss_pkg::result_t               result_o,

  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sdss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sdss_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sdss_pkg::ctrl_t   ctrl;
  sdss_pkg::status_t status;

  // sequencing of insertions and the visit readout
  sdss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (item_i.cmd),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy_o)
  );

  // config registers, sorted list store, sweep order and seek total
  sdss_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .track_i        (item_i.track),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ rtl/sdss_checker.sv @@
module sdss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input sdss_pkg::item_t   item_i,
  input logic              result_valid_o,
  input sdss_pkg::result_t result_o
);

  // visits come at most every other cycle
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes in consecutive cycles");

  // a visit that is not the last leaves the run going
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("run ended before its last visit");

  // the last visit closes the run
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy_o)
    else $error("block still busy on the last visit");

  // a start transfer always leads into work
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (item_i.cmd == sdss_pkg::CMD_START) |=> busy_o)
    else $error("start transfer did not begin a run");

  // no result appears out of an idle block
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without a preceding run");

endmodule

bind scan_disk_seek_scheduler sdss_checker u_sdss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

@@ tb/tb_scan_disk_seek_scheduler.sv @@
`timescale 1ns / 100ps

module tb_scan_disk_seek_scheduler;

  // index past the register list, the block must ignore writes to it
  localparam logic [sdss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = sdss_pkg::CFG_IDX_W'(3);

  // items in the whole run
  localparam int unsigned RAND_ITEMS    = 350;
  // items at the tail of the run that go with no idle bursts
  localparam int unsigned QUIET_TAIL    = 40;
  // margin after the last owed visit so that the block is idle again
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned MAX_PRINTS    = 50;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  sdss_pkg::item_t   item_i;
  logic              result_valid_o;
  sdss_pkg::result_t result_o;
  logic              cfg_we_i;
  logic [sdss_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [sdss_pkg::CFG_DATA_W-1:0] cfg_data_i;

  scan_disk_seek_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // one line of stimulus: either a full register setting or one item, with
  // the visits of a start optionally typed in by hand
  typedef struct {
    logic                            is_setting;
    logic [sdss_pkg::CFG_DATA_W-1:0] dt;
    logic [sdss_pkg::TRACK_W-1:0]    sh;
    logic [sdss_pkg::TRACK_W-1:0]    pt;
    sdss_pkg::item_t                 it;
    int                              n_typed;
    logic [sdss_pkg::TRACK_W-1:0]    t_trk [3];
    logic [sdss_pkg::TOTAL_W-1:0]    t_tot [3];
  } step_row_t;

  // shadow of the scheduler: registers, request store, head and total
  logic [sdss_pkg::CFG_DATA_W-1:0] cfg_disk;
  logic [sdss_pkg::TRACK_W-1:0]    cfg_head;
  logic [sdss_pkg::TRACK_W-1:0]    cfg_prev;
  logic [sdss_pkg::TRACK_W-1:0]    req_tracks [sdss_pkg::MAX_REQUESTS];
  int unsigned                     req_count;
  logic [sdss_pkg::TRACK_W-1:0]    head_pos;
  logic [sdss_pkg::TOTAL_W-1:0]    dist_sum;

  // visits worked out for the item just taken
  sdss_pkg::result_t sweep_buf [sdss_pkg::LIST_MAX];
  // visits still owed by the block, oldest first
  sdss_pkg::result_t pending_visits [$];
  step_row_t         dir_tab [$];

  int unsigned n_errors;
  int unsigned n_items;
  int unsigned n_runs;
  int unsigned n_checked;
  int unsigned n_settings;

  // clock, 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("timeout with %0d visits outstanding", pending_visits.size());
    $display("tb_scan_disk_seek_scheduler NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    n_errors++;
  endtask

  // last track of a disk, zero size counts as track 0, saturates at 16 bits
  function automatic int unsigned last_of(input logic [sdss_pkg::CFG_DATA_W-1:0] dt);
    if (dt == '0) begin
      return 0;
    end
    if (dt - 1 > 65535) begin
      return 65535;
    end
    return dt - 1;
  endfunction

  // move the head to trk, grow the running total and record the visit
  function automatic int emit_visit(input int k, input int unsigned trk);
    int unsigned d;
    d = (trk > head_pos) ? trk - head_pos : head_pos - trk;
    dist_sum = dist_sum + d[sdss_pkg::TOTAL_W-1:0];
    head_pos = trk[sdss_pkg::TRACK_W-1:0];
    sweep_buf[k] = '{visit_track: head_pos, seek_total: dist_sum, last: 1'b0};
    return k + 1;
  endfunction

  // scan sweep: returns the number of visits left in sweep_buf
  function automatic int scan_schedule(input sdss_pkg::item_t it);
    int unsigned lst [sdss_pkg::LIST_MAX];
    int unsigned n, i, j, v, split, lt;
    int k;
    k  = 0;
    lt = last_of(cfg_disk);
    if (it.cmd == sdss_pkg::CMD_LOAD) begin
      // a full store drops the load, tracks past the disk clamp to its edge
      if (req_count < sdss_pkg::MAX_REQUESTS) begin
        req_tracks[req_count] = (it.track > lt) ? lt[sdss_pkg::TRACK_W-1:0] : it.track;
        req_count++;
      end
      return 0;
    end
    n = 0;
    for (i = 0; i < req_count; i++) begin
      lst[n] = req_tracks[i];
      n++;
    end
    lst[n] = cfg_head;
    lst[n+1] = lt;
    lst[n+2] = 0;
    n = n + 3;
    // insertion sort, ascending
    for (i = 1; i < n; i++) begin
      v = lst[i];
      j = i;
      while (j > 0 && lst[j-1] > v) begin
        lst[j] = lst[j-1];
        j--;
      end
      lst[j] = v;
    end
    // split at the first copy of the head, later copies go to the upper part
    split = 0;
    while (split < n && lst[split] != cfg_head) split++;
    head_pos = cfg_head;
    dist_sum = '0;
    if (cfg_prev < cfg_head) begin
      for (i = split + 1; i < n; i++) k = emit_visit(k, lst[i]);
      for (i = split; i > 0; i--) k = emit_visit(k, lst[i-1]);
    end else begin
      for (i = split; i > 0; i--) k = emit_visit(k, lst[i-1]);
      for (i = split + 1; i < n; i++) k = emit_visit(k, lst[i]);
    end
    if (k > 0) begin
      sweep_buf[k-1].last = 1'b1;
    end
    req_count = 0;
    return k;
  endfunction

  function automatic step_row_t row_setting(input logic [sdss_pkg::CFG_DATA_W-1:0] dt,
                                            input logic [sdss_pkg::TRACK_W-1:0] sh,
                                            input logic [sdss_pkg::TRACK_W-1:0] pt);
    step_row_t r;
    r.is_setting = 1'b1;
    r.dt         = dt;
    r.sh         = sh;
    r.pt         = pt;
    r.it         = '0;
    r.n_typed    = 0;
    return r;
  endfunction

  function automatic step_row_t row_item(input logic cmd,
                                         input logic [sdss_pkg::TRACK_W-1:0] trk);
    step_row_t r;
    r.is_setting = 1'b0;
    r.dt         = '0;
    r.sh         = '0;
    r.pt         = '0;
    r.it         = '{cmd: cmd, track: trk};
    r.n_typed    = 0;
    return r;
  endfunction

  // start item whose visits are typed in, the last one carries the flag
  function automatic step_row_t row_typed(input int n,
                                          input logic [sdss_pkg::TRACK_W-1:0] t0,
                                          input logic [sdss_pkg::TOTAL_W-1:0] s0,
                                          input logic [sdss_pkg::TRACK_W-1:0] t1,
                                          input logic [sdss_pkg::TOTAL_W-1:0] s1,
                                          input logic [sdss_pkg::TRACK_W-1:0] t2,
                                          input logic [sdss_pkg::TOTAL_W-1:0] s2);
    step_row_t r;
    r = row_item(sdss_pkg::CMD_START, 16'($urandom));
    r.n_typed  = n;
    r.t_trk[0] = t0;
    r.t_tot[0] = s0;
    r.t_trk[1] = t1;
    r.t_tot[1] = s1;
    r.t_trk[2] = t2;
    r.t_tot[2] = s2;
    return r;
  endfunction

  // write all registers back to back, plus a stray write past the list
  task automatic program_regs(input logic [sdss_pkg::CFG_DATA_W-1:0] dt,
                              input logic [sdss_pkg::TRACK_W-1:0] sh,
                              input logic [sdss_pkg::TRACK_W-1:0] pt);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sdss_pkg::CFG_DISK_TRACKS;
    cfg_data_i  <= dt;
    @(posedge clk_i);
    // bit 16 is outside the register and must be dropped
    cfg_index_i <= sdss_pkg::CFG_START_HEAD;
    cfg_data_i  <= {1'($urandom), sh};
    @(posedge clk_i);
    cfg_index_i <= sdss_pkg::CFG_PREV_TRACK;
    cfg_data_i  <= {1'($urandom), pt};
    @(posedge clk_i);
    cfg_index_i <= CFG_UNUSED;
    cfg_data_i  <= sdss_pkg::CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cfg_disk = dt;
    cfg_head = sh;
    cfg_prev = pt;
    n_settings++;
  endtask

  // let the block run dry before touching its registers or ending
  task automatic settle();
    start_i <= 1'b0;
    while (pending_visits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one item transfer, then the visits it owes, then maybe an idle burst
  task automatic issue_item(input step_row_t row);
    int k, n;
    start_i <= 1'b1;
    item_i  <= row.it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    n = scan_schedule(row.it);
    if (row.n_typed > 0) begin
      for (k = 0; k < row.n_typed; k++) begin
        pending_visits.push_back('{visit_track: row.t_trk[k], seek_total: row.t_tot[k],
                                   last: 1'(k == row.n_typed - 1)});
      end
    end else begin
      for (k = 0; k < n; k++) pending_visits.push_back(sweep_buf[k]);
    end
    n_items++;
    if (row.it.cmd == sdss_pkg::CMD_START) begin
      n_runs++;
    end
    // idle bursts with junk on the item bus, none near the end
    if (n_items < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) begin
        item_i <= sdss_pkg::item_t'(17'($urandom));
        @(posedge clk_i);
      end
    end
  endtask

  // every strobe is one visit transfer, compare against the oldest owed one
  always @(posedge clk_i) begin : visit_check
    sdss_pkg::result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("visit to track %0d with none owed", result_o.visit_track));
      end else begin
        want = pending_visits.pop_front();
        n_checked++;
        if (result_o.visit_track !== want.visit_track) begin
          report_mismatch($sformatf("visit %0d track %0d, want %0d", n_checked,
                                    result_o.visit_track, want.visit_track));
        end
        if (result_o.seek_total !== want.seek_total) begin
          report_mismatch($sformatf("visit %0d total %0d, want %0d", n_checked,
                                    result_o.seek_total, want.seek_total));
        end
        if (result_o.last !== want.last) begin
          report_mismatch($sformatf("visit %0d last %b, want %b", n_checked,
                                    result_o.last, want.last));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned k, nload, lt;
    logic [sdss_pkg::CFG_DATA_W-1:0] dt;
    logic [sdss_pkg::TRACK_W-1:0] sh, pt, trk;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cfg_disk    = sdss_pkg::DISK_TRACKS_RST;
    cfg_head    = '0;
    cfg_prev    = '0;
    req_count   = 0;
    head_pos    = '0;
    dist_sum    = '0;
    n_errors    = 0;
    n_items     = 0;
    n_runs      = 0;
    n_checked   = 0;
    n_settings  = 0;

    // reset settings, bare run: edges 0 and 199 only
    dir_tab.push_back(row_typed(2, 0, 0, 199, 199, 0, 0));
    // zero size disk, every track clamps to 0
    dir_tab.push_back(row_setting(0, 0, 0));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 5));
    dir_tab.push_back(row_typed(3, 0, 0, 0, 0, 0, 0));
    // oversized disk saturates the last track, head at the top sweeps up first
    dir_tab.push_back(row_setting(17'h1FFFF, 16'hFFFF, 0));
    dir_tab.push_back(row_typed(2, 16'hFFFF, 0, 0, 65535, 0, 0));
    // largest legal disk, widest track, down preferred but nothing below the head at 0, so it sweeps up
    dir_tab.push_back(row_setting(65536, 0, 16'hFFFF));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 16'hFFFF));
    dir_tab.push_back(row_typed(3, 0, 0, 16'hFFFF, 65535, 16'hFFFF, 65535));
    // track past the disk clamps to track 99
    dir_tab.push_back(row_setting(100, 50, 0));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 16'hFFFF));
    dir_tab.push_back(row_typed(3, 99, 49, 99, 49, 0, 148));
    // head beyond the disk is not clamped
    dir_tab.push_back(row_setting(100, 500, 600));
    dir_tab.push_back(row_typed(2, 99, 401, 0, 500, 0, 0));
    // copies of the head land in the upper part
    dir_tab.push_back(row_setting(200, 10, 20));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 10));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 10));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 5));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 150));
    dir_tab.push_back(row_item(sdss_pkg::CMD_START, 0));
    // alternating bit patterns, previous track just below the head
    dir_tab.push_back(row_setting(65536, 16'h8000, 16'h7FFF));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 0));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 16'hFFFF));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 16'h5555));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 16'hAAAA));
    dir_tab.push_back(row_item(sdss_pkg::CMD_LOAD, 1));
    dir_tab.push_back(row_item(sdss_pkg::CMD_START, 16'hFFFF));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_setting) begin
        settle();
        program_regs(dir_tab[r].dt, dir_tab[r].sh, dir_tab[r].pt);
      end else begin
        issue_item(dir_tab[r]);
      end
    end

    // overfill the store once so the dropped loads are seen early
    settle();
    program_regs(300, 150, 149);
    for (k = 0; k < sdss_pkg::MAX_REQUESTS + 2; k++) begin
      issue_item(row_item(sdss_pkg::CMD_LOAD, 16'($urandom_range(0, 400))));
    end
    issue_item(row_item(sdss_pkg::CMD_START, 16'($urandom)));

    // random runs: a handful of loads, now and then enough to fill the store, then a start; new settings now and then
    while (n_items < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0:       dt = 0;
          1:       dt = 1;
          2:       dt = 2;
          3:       dt = 65536;
          4:       dt = sdss_pkg::CFG_DATA_W'($urandom_range(65537, 131071));
          5:       dt = 17'h1FFFF;
          6, 7:    dt = sdss_pkg::CFG_DATA_W'($urandom_range(3, 300));
          default: dt = sdss_pkg::CFG_DATA_W'($urandom_range(1, 65536));
        endcase
        lt = last_of(dt);
        case ($urandom_range(0, 5))
          0:       sh = 0;
          1:       sh = lt[sdss_pkg::TRACK_W-1:0];
          2:       sh = 16'hFFFF;
          3:       sh = (lt + 2000 > 65535) ? 16'hFFFF : 16'(lt + $urandom_range(1, 2000));
          default: sh = 16'($urandom_range(0, lt));
        endcase
        case ($urandom_range(0, 5))
          0:       pt = sh;
          1:       pt = sh - 1'b1;
          2:       pt = sh + 1'b1;
          3:       pt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: pt = 16'($urandom);
        endcase
        settle();
        program_regs(dt, sh, pt);
      end
      nload = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 36) : $urandom_range(0, 6);
      lt = last_of(cfg_disk);
      for (k = 0; k < nload; k++) begin
        case ($urandom_range(0, 7))
          0:       trk = 16'($urandom);
          1:       trk = 0;
          2:       trk = lt[sdss_pkg::TRACK_W-1:0];
          3:       trk = cfg_head;
          4:       trk = (lt + 2000 > 65535) ? 16'hFFFF : 16'(lt + $urandom_range(1, 2000));
          5:       trk = cfg_head + 16'($urandom_range(0, 6)) - 16'd3;
          default: trk = 16'($urandom_range(0, lt));
        endcase
        issue_item(row_item(sdss_pkg::CMD_LOAD, trk));
      end
      issue_item(row_item(sdss_pkg::CMD_START, 16'($urandom)));
    end

    settle();
    $display("covered %0d items in %0d sweeps under %0d register settings",
             n_items, n_runs, n_settings);
    $display("%0d visits compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_scan_disk_seek_scheduler OK");
    end else begin
      $display("tb_scan_disk_seek_scheduler NOT OK");
    end
    $finish;
  end

endmodule
